/* rtl/core/mvna_pkg.sv */
// Shared types, constants and helpers of the vertex normal averaging block.
`timescale 1ns / 1ps
package mvna_pkg;

	localparam int MAX_VERTICES = 4096;
	localparam int AW           = $clog2(MAX_VERTICES);
	localparam int IDX_W        = 12;
	localparam int POS_W        = 16;
	localparam int SUM_W        = 52;
	localparam int CNT_W        = 16;
	localparam int DIF_W        = 17;
	localparam int PRD_W        = 34;
	localparam int FACE_W       = 35;
	localparam int MAG_LIM      = 30;
	localparam int SQ_W         = 62;
	localparam int LEN_W        = 31;
	localparam int QUO_W        = 15;
	localparam int NUM_W        = 46;
	localparam int NRM_W        = 16;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_TRI   = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_POS, S_DIFF, S_MUL, S_CROSS, S_UPD_RD, S_UPD_WR,
		S_RD, S_CHK, S_SHIFT, S_SQ, S_SQRT, S_DIVSET, S_DIV, S_FIN
	} state_t;

	typedef struct packed {
		logic [CNT_W-1:0]        cnt;
		logic signed [SUM_W-1:0] z;
		logic signed [SUM_W-1:0] y;
		logic signed [SUM_W-1:0] x;
	} sum_rec_t;

	typedef struct packed {
		logic signed [POS_W-1:0] z;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] x;
	} pos_rec_t;

	function automatic logic in_range(input logic [IDX_W-1:0] i);
		return {5'd0, i} < 17'(MAX_VERTICES);
	endfunction

endpackage

/* rtl/core/mvna_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module mvna_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/core/mesh_vertex_normal_average.sv */
// Top level: per-vertex normal accumulation and unit normal readout.
`timescale 1ns / 1ps
// Usage
//   Input channel (in_valid/in_ready) takes one word: operation, three vertex
//   indices and a Q8.8 position. Output channel (out_valid/out_ready) returns
//   exactly one word per input word: Q1.14 unit normal, face count, status.
//   Load, and reads of out-of-range vertices: straight to the final state that
//   fills the output register; reads of unused vertices: S_RD, S_CHK first.
//   Add triangle: 3 position reads, difference, product and cross-product
//   steps, then 3 read-modify-write passes on the sum memory.
//   Read normal: RAM read, up to 22 right shifts, squaring of the three
//   magnitudes, 31 square-root steps, then a bit-serial divide per component.
//   Clear sums: a sweep of all 4096 sum memory entries, then the result word.
//   One word is worked on at a time; in_ready is high only while idle, so a
//   new word is taken only after the last has reached the output register.
//   After reset the same sweep of all entries zeroes sums and counts before
//   in_ready rises. Positions are not cleared.
//   A stalled receiver holds the result in the output register; the next input
//   word is still accepted and worked on, and it waits in its final state
//   until the output register frees.
module mesh_vertex_normal_average (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        operation,
	input  logic [mvna_pkg::IDX_W-1:0]        first_index,
	input  logic [mvna_pkg::IDX_W-1:0]        second_index,
	input  logic [mvna_pkg::IDX_W-1:0]        third_index,
	input  logic signed [mvna_pkg::POS_W-1:0] pos_x,
	input  logic signed [mvna_pkg::POS_W-1:0] pos_y,
	input  logic signed [mvna_pkg::POS_W-1:0] pos_z,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [mvna_pkg::NRM_W-1:0] normal_x,
	output logic signed [mvna_pkg::NRM_W-1:0] normal_y,
	output logic signed [mvna_pkg::NRM_W-1:0] normal_z,
	output logic [mvna_pkg::CNT_W-1:0]        face_count,
	output logic                              status
);
	import mvna_pkg::*;

	localparam logic [AW-1:0] CLR_LAST = AW'(MAX_VERTICES - 1);

	// control
	state_t          state_q, state_d;
	logic [1:0]      step_q;
	logic [4:0]      iter_q;
	logic [AW-1:0]   clr_cnt_q;
	logic            clr_op_q;
	logic            out_valid_q;

	// memory ports
	logic            pos_we;
	logic [AW-1:0]   pos_raddr;
	pos_rec_t        pos_rdata;
	logic            sum_we;
	logic [AW-1:0]   sum_waddr, sum_raddr;
	sum_rec_t        sum_wdata, sum_rdata, sum_upd;

	// datapath
	logic [AW-1:0]             corner_q [3];
	pos_rec_t                  pos_q [3];
	logic signed [DIF_W-1:0]   u_q [3];
	logic signed [DIF_W-1:0]   v_q [3];
	logic signed [PRD_W-1:0]   prd_q [6];
	logic signed [FACE_W-1:0]  n_q [3];
	logic [SUM_W-1:0]          mag_q [3];
	logic                      neg_q [3];
	logic [SQ_W-1:0]           sq_acc_q, sq_acc_d;
	logic [SQ_W-1:0]           sq_v_q, sq_res_q, sq_bit_q;
	logic [SQ_W:0]             sq_try;
	logic [LEN_W:0]            div_d;
	logic [LEN_W:0]            div_rem_q;
	logic [LEN_W+1:0]          div_rem2;
	logic [QUO_W-1:0]          div_low_q, div_quo_q, quo_fin;
	logic [NUM_W-1:0]          div_num;
	logic                      div_ge;
	logic signed [NRM_W-1:0]   nrm_q [3];
	logic [CNT_W-1:0]          res_cnt_q;
	logic                      res_deg_q;
	logic                      mag_big;
	logic                      tri_ok;
	logic [2*MAG_LIM-1:0]      sq_term;

	mvna_ram #(.WIDTH($bits(pos_rec_t)), .DEPTH(MAX_VERTICES)) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.waddr (AW'(first_index)),
		.wdata ({pos_z, pos_y, pos_x}),
		.raddr (pos_raddr),
		.rdata (pos_rdata)
	);

	mvna_ram #(.WIDTH($bits(sum_rec_t)), .DEPTH(MAX_VERTICES)) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata (sum_wdata),
		.raddr (sum_raddr),
		.rdata (sum_rdata)
	);

	function automatic logic signed [SUM_W-1:0] sat_add(
		input logic signed [SUM_W-1:0]  s,
		input logic signed [FACE_W-1:0] d
	);
		logic signed [SUM_W:0] r;
		r = {s[SUM_W-1], s} + (SUM_W+1)'(d);
		if (r[SUM_W] != r[SUM_W-1]) begin
			return r[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end
		return r[SUM_W-1:0];
	endfunction

	function automatic logic [SUM_W-1:0] mag_of(input logic signed [SUM_W-1:0] v);
		return v[SUM_W-1] ? SUM_W'(-v) : v;
	endfunction

	assign tri_ok  = in_range(first_index) && in_range(second_index) &&
		in_range(third_index);
	assign mag_big = ((mag_q[0] | mag_q[1] | mag_q[2]) >> MAG_LIM) != '0;

	// read-modify-write of one corner's record
	always_comb begin
		sum_upd.x   = sat_add(sum_rdata.x, n_q[0]);
		sum_upd.y   = sat_add(sum_rdata.y, n_q[1]);
		sum_upd.z   = sat_add(sum_rdata.z, n_q[2]);
		sum_upd.cnt = (sum_rdata.cnt == '1) ? sum_rdata.cnt : sum_rdata.cnt + 1'b1;
	end

	// squaring, root step and divide step
	assign sq_term  = mag_q[step_q][MAG_LIM-1:0] * mag_q[step_q][MAG_LIM-1:0];
	assign sq_acc_d = sq_acc_q + SQ_W'(sq_term);
	assign sq_try   = {1'b0, sq_res_q} + {1'b0, sq_bit_q};
	assign div_d    = {sq_res_q[LEN_W-1:0], 1'b0};
	assign div_num  = NUM_W'({mag_q[step_q][MAG_LIM-1:0], {QUO_W{1'b0}}}) +
		NUM_W'(sq_res_q);
	assign div_rem2 = {div_rem_q, div_low_q[QUO_W-1]};
	assign div_ge   = div_rem2 >= {1'b0, div_d};
	assign quo_fin  = {div_quo_q[QUO_W-2:0], div_ge};

	// next state and memory control
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		pos_we    = 1'b0;
		pos_raddr = corner_q[0];
		sum_we    = 1'b0;
		sum_waddr = corner_q[0];
		sum_wdata = sum_upd;
		sum_raddr = corner_q[0];
		unique case (state_q)
			S_CLEAR: begin
				sum_we    = 1'b1;
				sum_waddr = clr_cnt_q;
				sum_wdata = '0;
				if (clr_cnt_q == CLR_LAST) begin
					state_d = clr_op_q ? S_FIN : S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (op_t'(operation))
						OP_LOAD: begin
							pos_we  = in_range(first_index);
							state_d = S_FIN;
						end
						OP_TRI:   state_d = tri_ok ? S_POS : S_FIN;
						OP_READ:  state_d = in_range(first_index) ? S_RD : S_FIN;
						OP_CLEAR: state_d = S_CLEAR;
					endcase
				end
			end
			S_POS: begin
				if (step_q != 2'd3) begin
					pos_raddr = corner_q[step_q];
				end else begin
					state_d = S_DIFF;
				end
			end
			S_DIFF:  state_d = S_MUL;
			S_MUL:   state_d = S_CROSS;
			S_CROSS: state_d = S_UPD_RD;
			S_UPD_RD: begin
				sum_raddr = corner_q[step_q];
				state_d   = S_UPD_WR;
			end
			S_UPD_WR: begin
				sum_we    = 1'b1;
				sum_waddr = corner_q[step_q];
				state_d   = (step_q == 2'd2) ? S_FIN : S_UPD_RD;
			end
			S_RD:  state_d = S_CHK;
			S_CHK: begin
				if (sum_rdata.cnt == '0 ||
					(sum_rdata.x == '0 && sum_rdata.y == '0 && sum_rdata.z == '0)) begin
					state_d = S_FIN;
				end else begin
					state_d = S_SHIFT;
				end
			end
			S_SHIFT: if (!mag_big) state_d = S_SQ;
			S_SQ:    if (step_q == 2'd2) state_d = S_SQRT;
			S_SQRT:  if (iter_q == 5'd30) state_d = S_DIVSET;
			S_DIVSET: state_d = S_DIV;
			S_DIV: begin
				if (iter_q == 5'(QUO_W - 1)) begin
					state_d = (step_q == 2'd2) ? S_FIN : S_DIVSET;
				end
			end
			S_FIN: if (!out_valid_q || out_ready) state_d = S_IDLE;
		endcase
	end

	// control registers and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			step_q      <= '0;
			iter_q      <= '0;
			clr_cnt_q   <= '0;
			clr_op_q    <= 1'b0;
			out_valid_q <= 1'b0;
			normal_x    <= '0;
			normal_y    <= '0;
			normal_z    <= '0;
			face_count  <= '0;
			status      <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_CLEAR: clr_cnt_q <= clr_cnt_q + 1'b1;
				S_IDLE: begin
					step_q    <= '0;
					iter_q    <= '0;
					clr_cnt_q <= '0;
					clr_op_q  <= 1'b1;
				end
				S_POS:    step_q <= step_q + 1'b1;
				S_UPD_WR: step_q <= (step_q == 2'd2) ? 2'd0 : step_q + 1'b1;
				S_SQ:     step_q <= (step_q == 2'd2) ? 2'd0 : step_q + 1'b1;
				S_SQRT:   iter_q <= (iter_q == 5'd30) ? 5'd0 : iter_q + 1'b1;
				S_DIV: begin
					if (iter_q == 5'(QUO_W - 1)) begin
						iter_q <= '0;
						step_q <= step_q + 1'b1;
					end else begin
						iter_q <= iter_q + 1'b1;
					end
				end
				default: ;
			endcase
			if (state_q == S_FIN && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
				normal_x    <= nrm_q[0];
				normal_y    <= nrm_q[1];
				normal_z    <= nrm_q[2];
				face_count  <= res_cnt_q;
				status      <= res_deg_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				corner_q[0] <= AW'(first_index);
				corner_q[1] <= AW'(second_index);
				corner_q[2] <= AW'(third_index);
				for (int k = 0; k < 3; k++) nrm_q[k] <= '0;
				res_cnt_q <= '0;
				res_deg_q <= (op_t'(operation) == OP_READ);
			end
			S_POS: if (step_q != 2'd0) pos_q[step_q - 2'd1] <= pos_rdata;
			S_DIFF: begin
				u_q[0] <= DIF_W'(pos_q[0].x) - DIF_W'(pos_q[1].x);
				u_q[1] <= DIF_W'(pos_q[0].y) - DIF_W'(pos_q[1].y);
				u_q[2] <= DIF_W'(pos_q[0].z) - DIF_W'(pos_q[1].z);
				v_q[0] <= DIF_W'(pos_q[0].x) - DIF_W'(pos_q[2].x);
				v_q[1] <= DIF_W'(pos_q[0].y) - DIF_W'(pos_q[2].y);
				v_q[2] <= DIF_W'(pos_q[0].z) - DIF_W'(pos_q[2].z);
			end
			S_MUL: begin
				prd_q[0] <= u_q[1] * v_q[2];
				prd_q[1] <= u_q[2] * v_q[1];
				prd_q[2] <= u_q[2] * v_q[0];
				prd_q[3] <= u_q[0] * v_q[2];
				prd_q[4] <= u_q[0] * v_q[1];
				prd_q[5] <= u_q[1] * v_q[0];
			end
			S_CROSS: begin
				n_q[0] <= FACE_W'(prd_q[0]) - FACE_W'(prd_q[1]);
				n_q[1] <= FACE_W'(prd_q[2]) - FACE_W'(prd_q[3]);
				n_q[2] <= FACE_W'(prd_q[4]) - FACE_W'(prd_q[5]);
			end
			S_CHK: begin
				res_cnt_q <= sum_rdata.cnt;
				res_deg_q <= (sum_rdata.cnt == '0) ||
					(sum_rdata.x == '0 && sum_rdata.y == '0 && sum_rdata.z == '0);
				mag_q[0]  <= mag_of(sum_rdata.x);
				mag_q[1]  <= mag_of(sum_rdata.y);
				mag_q[2]  <= mag_of(sum_rdata.z);
				neg_q[0]  <= sum_rdata.x[SUM_W-1];
				neg_q[1]  <= sum_rdata.y[SUM_W-1];
				neg_q[2]  <= sum_rdata.z[SUM_W-1];
				sq_acc_q  <= '0;
			end
			S_SHIFT: begin
				if (mag_big) begin
					for (int k = 0; k < 3; k++) mag_q[k] <= mag_q[k] >> 1;
				end
			end
			S_SQ: begin
				sq_acc_q <= sq_acc_d;
				sq_v_q   <= sq_acc_d;
				sq_res_q <= '0;
				sq_bit_q <= SQ_W'(1) << (SQ_W - 2);
			end
			S_SQRT: begin
				if ({1'b0, sq_v_q} >= sq_try) begin
					sq_v_q   <= sq_v_q - sq_try[SQ_W-1:0];
					sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
				end else begin
					sq_res_q <= sq_res_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
			end
			S_DIVSET: begin
				div_rem_q <= (LEN_W+1)'(div_num[NUM_W-1:QUO_W]);
				div_low_q <= div_num[QUO_W-1:0];
				div_quo_q <= '0;
			end
			S_DIV: begin
				div_rem_q <= div_ge ? (LEN_W+1)'(div_rem2 - {1'b0, div_d})
					: div_rem2[LEN_W:0];
				div_low_q <= div_low_q << 1;
				div_quo_q <= quo_fin;
				if (iter_q == 5'(QUO_W - 1)) begin
					nrm_q[step_q] <= neg_q[step_q] ? -NRM_W'(quo_fin) : NRM_W'(quo_fin);
				end
			end
			default: ;
		endcase
	end

	// the shift loop must leave every magnitude inside the squaring range
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SQ |-> !mag_big)
		else $error("magnitude out of range at squaring");

	// the sum memory is written only by the sweep or a corner update
	assert property (@(posedge clk) disable iff (!arst_n)
		sum_we |-> (state_q == S_CLEAR || state_q == S_UPD_WR))
		else $error("unexpected sum memory write");

	// a degenerate result carries no direction
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> normal_x == '0 && normal_y == '0 && normal_z == '0)
		else $error("degenerate result with nonzero normal");

	// unit components stay within one
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> normal_x <= 16'sd16384 && normal_x >= -16'sd16384 &&
			normal_y <= 16'sd16384 && normal_y >= -16'sd16384 &&
			normal_z <= 16'sd16384 && normal_z >= -16'sd16384)
		else $error("normal component exceeds unit");

endmodule
